// ===== rtl/interval_set_tracker_top_macros.svh =====
// assertion helpers shared by the checker
`ifndef INTERVAL_SET_TRACKER_TOP_MACROS_SVH
`define INTERVAL_SET_TRACKER_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define IST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval set tracker check failed");

// next-cycle implication, quiet during reset
`define IST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval set tracker check failed");

`endif

// ===== rtl/ist_pkg.sv =====
package ist_pkg;

  // request operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } ist_state_t;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic rotate;
    logic wr;
    logic commit;
  } cell_ctl_t;

endpackage

// ===== rtl/ist_cell.sv =====
module ist_cell
  import ist_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int IDX_W      = 6,
  parameter int COORD_BITS = 30
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [COORD_BITS-1:0] wr_start,
  input  logic [COORD_BITS-1:0] wr_end,
  input  logic [COORD_BITS-1:0] nb_start,
  input  logic [COORD_BITS-1:0] nb_end,
  output logic [COORD_BITS-1:0] a_start,
  output logic [COORD_BITS-1:0] a_end
);

  logic [COORD_BITS-1:0] b_start;
  logic [COORD_BITS-1:0] b_end;

  // live entry: rotates toward the head, or takes the rebuilt entry
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      a_start <= b_start;
      a_end   <= b_end;
    end else if (ctl.rotate) begin
      a_start <= nb_start;
      a_end   <= nb_end;
    end
  end

  // rebuild entry written when the write pointer lands here
  always_ff @(posedge clk) begin
    if (ctl.wr && (wr_idx == IDX_W'(INDEX))) begin
      b_start <= wr_start;
      b_end   <= wr_end;
    end
  end

endmodule

// ===== rtl/ist_ctrl.sv =====
module ist_ctrl
  import ist_pkg::*;
#(
  parameter int MAX_INTERVALS = 64,
  parameter int COORD_BITS    = 30,
  parameter int IDX_W         = 6,
  parameter int CNT_W         = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [COORD_BITS-1:0] left,
  input  logic [COORD_BITS-1:0] right,
  input  logic [COORD_BITS-1:0] head_start,
  input  logic [COORD_BITS-1:0] head_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  covered,
  output logic                  table_full,
  output cell_ctl_t             ctl,
  output logic [IDX_W-1:0]      wr_idx,
  output logic [COORD_BITS-1:0] wr_start,
  output logic [COORD_BITS-1:0] wr_end
);

  ist_state_t state, state_next;

  logic [1:0]            op_q;
  logic                  active;
  logic [COORD_BITS-1:0] lo, hi, ms, me;
  logic [IDX_W-1:0]      step;
  logic [CNT_W-1:0]      count, wp;
  logic                  pend_v, placed, ovf, cov;
  logic [COORD_BITS-1:0] pend_s, pend_e;

  logic                  rd, last_step, is_add, is_rem, can_write, done_go;
  logic                  c0v, c1v, wv, rv, placed_n, cov_n, flush_end;
  logic [COORD_BITS-1:0] c0s, c0e, c1s, c1e, ws, we, rs, re, ms_n, me_n;

  assign is_add    = active && (op_q == OP_ADD);
  assign is_rem    = active && (op_q == OP_REMOVE);
  assign rd        = (state == ST_SCAN) && (CNT_W'(step) < count);
  assign last_step = (step == IDX_W'(MAX_INTERVALS - 1));
  assign can_write = (wp < CNT_W'(MAX_INTERVALS));
  assign done_go   = !out_valid || out_ready;
  assign flush_end = !pend_v && (placed || !is_add);

  // per-entry merge / split decision
  always_comb begin
    c0v = 1'b0; c0s = head_start; c0e = head_end;
    c1v = 1'b0; c1s = head_start; c1e = head_end;
    ms_n = ms; me_n = me; placed_n = placed; cov_n = cov;
    if (rd) begin
      if (is_add) begin
        if (head_end < lo) begin
          c0v = 1'b1;
        end else if (head_start > hi) begin
          if (!placed) begin
            c0v = 1'b1; c0s = ms; c0e = me;
            c1v = 1'b1;
            placed_n = 1'b1;
          end else begin
            c0v = 1'b1;
          end
        end else begin
          if (head_start < ms) ms_n = head_start;
          if (head_end > me)   me_n = head_end;
        end
      end else if (is_rem) begin
        if (head_end <= lo || head_start >= hi) begin
          c0v = 1'b1;
        end else begin
          c0v = head_start < lo; c0e = lo;
          c1v = head_end > hi;   c1s = hi;
        end
      end else if (active && op_q == OP_QUERY) begin
        if (head_start <= lo && head_end >= hi) cov_n = 1'b1;
      end
    end else if (state == ST_FLUSH && is_add && !placed) begin
      // merged interval goes last when nothing followed it
      c0v = 1'b1; c0s = ms; c0e = me;
      placed_n = 1'b1;
    end
  end

  // one entry written per cycle, overflow kept in the pending slot
  always_comb begin
    wv = pend_v || c0v || c1v;
    rv = 1'b0; rs = c0s; re = c0e;
    ws = c1s; we = c1e;
    if (pend_v) begin
      ws = pend_s; we = pend_e;
      rv = c0v || c1v;
      rs = c0v ? c0s : c1s;
      re = c0v ? c0e : c1e;
    end else if (c0v) begin
      ws = c0s; we = c0e;
      rv = c1v; rs = c1s; re = c1e;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SCAN;
      ST_SCAN:  if (last_step) state_next = ST_FLUSH;
      ST_FLUSH: if (flush_end) state_next = ST_DONE;
      ST_DONE:  if (done_go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs to the chain
  always_comb begin
    in_ready   = (state == ST_IDLE);
    ctl.rotate = (state == ST_SCAN);
    ctl.wr     = wv && can_write && (state == ST_SCAN || state == ST_FLUSH);
    ctl.commit = (state == ST_DONE) && done_go && (is_add || is_rem) && !ovf;
    wr_idx     = wp[IDX_W-1:0];
    wr_start   = ws;
    wr_end     = we;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && done_go) begin
        out_valid <= 1'b1;
        if (ctl.commit) count <= wp;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers of the current request
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op_q <= op; lo <= left; hi <= right; ms <= left; me <= right;
        active <= left < right;
        step <= '0; wp <= '0; pend_v <= 1'b0; placed <= 1'b0;
        ovf <= 1'b0; cov <= 1'b0;
      end
      ST_SCAN, ST_FLUSH: begin
        step <= step + 1'b1;
        ms <= ms_n; me <= me_n; placed <= placed_n; cov <= cov_n;
        pend_v <= rv; pend_s <= rs; pend_e <= re;
        if (wv) begin
          if (can_write) wp <= wp + 1'b1;
          else ovf <= 1'b1;
        end
      end
      ST_DONE: begin
        if (done_go) begin
          covered    <= cov;
          table_full <= ovf && (is_add || is_rem);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/interval_set_tracker_top.sv =====
// channel  | handshake           | payload
// request  | in_valid/in_ready   | op, left, right
// result   | out_valid/out_ready | covered, table_full
//
// each request runs through the scan, flush and done states: the cell chain
// rotates once all the way round so the head cell sees every entry,
// then the flush state drains pending entries, then the result loads.
// reset clears the entry count; the cell contents are not reset.
// a new request is taken while a finished result still waits.
module interval_set_tracker_top
  import ist_pkg::*;
#(
  parameter int MAX_INTERVALS = 64,
  parameter int COORD_BITS    = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [COORD_BITS-1:0] left,
  input  logic [COORD_BITS-1:0] right,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  covered,
  output logic                  table_full
);

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  cell_ctl_t             ctl;
  logic [IDX_W-1:0]      wr_idx;
  logic [COORD_BITS-1:0] wr_start, wr_end;
  logic [COORD_BITS-1:0] a_start [MAX_INTERVALS];
  logic [COORD_BITS-1:0] a_end   [MAX_INTERVALS];

  // sequencer and merge / split unit
  ist_ctrl #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .COORD_BITS   (COORD_BITS),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .op, .left, .right,
    .head_start(a_start[0]),
    .head_end  (a_end[0]),
    .out_valid, .out_ready, .covered, .table_full,
    .ctl, .wr_idx, .wr_start, .wr_end
  );

  // ring of entry cells, head at index zero
  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
    ist_cell #(
      .INDEX     (k),
      .IDX_W     (IDX_W),
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk,
      .ctl,
      .wr_idx,
      .wr_start,
      .wr_end,
      .nb_start(a_start[(k + 1) % MAX_INTERVALS]),
      .nb_end  (a_end[(k + 1) % MAX_INTERVALS]),
      .a_start (a_start[k]),
      .a_end   (a_end[k])
    );
  end

endmodule

// ===== rtl/ist_checker.sv =====
`include "interval_set_tracker_top_macros.svh"

module ist_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic covered,
  input logic table_full
);

  // a stalled result stays
  `IST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `IST_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(covered) && $stable(table_full))
  // a request keeps the block busy in the next cycle
  `IST_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  // a query never overflows and a table update never reports coverage
  `IST_ASSERT_NOW(a_flags_excl, out_valid, !(covered && table_full))

endmodule

bind interval_set_tracker_top ist_checker u_ist_checker (.*);
